// File: hdl/bitmap_first_fit_allocator_assert.svh
// ----------------------------------------------------------------------------
// bitmap first-fit allocator assertion macros
// shared concurrent assertion forms used by the allocator modules
// ----------------------------------------------------------------------------
`ifndef BITMAP_FIRST_FIT_ALLOCATOR_ASSERT_SVH
`define BITMAP_FIRST_FIT_ALLOCATOR_ASSERT_SVH

// same-cycle implication
`define BFFA_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define BFFA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hdl/bffa_pkg.sv
// ----------------------------------------------------------------------------
// bffa_pkg
// types and constants shared by the bitmap first-fit allocator modules
// ----------------------------------------------------------------------------
package bffa_pkg;

   // field widths
   localparam int UNIT_W   = 12;
   localparam int CFG_W    = 13;
   localparam int BASE_W   = 14;
   localparam int STATUS_W = 2;
   localparam int TDATA_W  = 16;

   // configuration port
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;
   localparam logic CSR_IDX_UNITS_IN_USE = 1'b0;
   localparam logic [CFG_W-1:0] CFG_RESET = 13'd4096;

   // result status codes
   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd2;

   // request kinds
   localparam logic MODE_ALLOC = 1'b0;
   localparam logic MODE_FREE  = 1'b1;

   typedef enum logic [2:0] {
      STATE_CLEAR,
      STATE_IDLE,
      STATE_ALLOC,
      STATE_SEEK,
      STATE_FREE_WR,
      STATE_FINISH
   } bffa_state_type;

   typedef struct packed {
      logic clr_step;
      logic load_req;
      logic alloc_scan;
      logic free_seek;
      logic free_write;
      logic load_rsp;
   } bffa_cmd_type;

   typedef struct packed {
      logic clr_last;
      logic found;
      logic full;
      logic range_err;
      logic word_hit;
      logic out_free;
   } bffa_sts_type;

endpackage

// File: hdl/bffa_ctrl.sv
// ----------------------------------------------------------------------------
// bffa_ctrl
// sequencer for clearing, allocate scans, free read-modify-writes and replies
// ----------------------------------------------------------------------------
`include "bitmap_first_fit_allocator_assert.svh"

module bffa_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic                  req_mode,
   input  bffa_pkg::bffa_sts_type sts,
   output bffa_pkg::bffa_cmd_type cmd
);

   bffa_pkg::bffa_state_type state_ff;
   bffa_pkg::bffa_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bffa_pkg::STATE_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bffa_pkg::STATE_CLEAR: begin
            if (sts.clr_last) state_in = bffa_pkg::STATE_IDLE;
         end
         bffa_pkg::STATE_IDLE: begin
            if (req_tvalid) begin
               if (req_mode == bffa_pkg::MODE_FREE) state_in = bffa_pkg::STATE_SEEK;
               else state_in = bffa_pkg::STATE_ALLOC;
            end
         end
         bffa_pkg::STATE_ALLOC: begin
            if (sts.found || sts.full) state_in = bffa_pkg::STATE_FINISH;
         end
         bffa_pkg::STATE_SEEK: begin
            if (sts.range_err) state_in = bffa_pkg::STATE_FINISH;
            else if (sts.word_hit) state_in = bffa_pkg::STATE_FREE_WR;
         end
         bffa_pkg::STATE_FREE_WR: begin
            state_in = bffa_pkg::STATE_FINISH;
         end
         bffa_pkg::STATE_FINISH: begin
            if (sts.out_free) state_in = bffa_pkg::STATE_IDLE;
         end
         default: begin
            state_in = bffa_pkg::STATE_CLEAR;
         end
      endcase
   end

   // outputs
   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         bffa_pkg::STATE_CLEAR: begin
            cmd.clr_step = 1'b1;
         end
         bffa_pkg::STATE_IDLE: begin
            req_tready   = 1'b1;
            cmd.load_req = req_tvalid;
         end
         bffa_pkg::STATE_ALLOC: begin
            cmd.alloc_scan = 1'b1;
         end
         bffa_pkg::STATE_SEEK: begin
            cmd.free_seek = 1'b1;
         end
         bffa_pkg::STATE_FREE_WR: begin
            cmd.free_write = 1'b1;
         end
         bffa_pkg::STATE_FINISH: begin
            cmd.load_rsp = sts.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   `BFFA_ASSERT_NEXT(a_accept_leaves_idle, clock, reset, req_tvalid && req_tready,
      state_ff != bffa_pkg::STATE_IDLE, "accepted item did not start work")
   `BFFA_ASSERT_NEXT(a_finish_returns_idle, clock, reset,
      state_ff == bffa_pkg::STATE_FINISH && sts.out_free,
      state_ff == bffa_pkg::STATE_IDLE, "reply handed off but sequencer not idle")

endmodule

// File: hdl/bffa_datapath.sv
// ----------------------------------------------------------------------------
// bffa_datapath
// bitmap word memory, scan pointers, lowest-free-bit search and reply register
// ----------------------------------------------------------------------------
`include "bitmap_first_fit_allocator_assert.svh"

module bffa_datapath #(
   parameter int NUM_UNITS = 4096,
   parameter int WORD_BITS = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  bffa_pkg::bffa_cmd_type                cmd,
   output bffa_pkg::bffa_sts_type                sts,
   input  logic [bffa_pkg::CFG_W-1:0]            limit,
   input  logic [bffa_pkg::UNIT_W-1:0]           req_unit,
   input  logic                                 rsp_tready,
   output logic                                 rsp_tvalid,
   output logic [bffa_pkg::STATUS_W-1:0]         rsp_status,
   output logic [bffa_pkg::UNIT_W-1:0]           rsp_unit
);

   localparam int NUM_WORDS = (NUM_UNITS + WORD_BITS - 1) / WORD_BITS;
   localparam int WADDR_W   = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
   localparam int BIT_W     = $clog2(WORD_BITS);
   localparam int BASE_W    = bffa_pkg::BASE_W;

   logic [WORD_BITS-1:0] mem [NUM_WORDS];
   logic [WORD_BITS-1:0] rd_data_ff;

   logic [WADDR_W-1:0]  addr_ff, addr_in;
   logic [BASE_W-1:0]   base_ff, base_in;
   logic                chk_vld_ff, chk_vld_in;
   logic [WADDR_W-1:0]  chk_addr_ff, chk_addr_in;
   logic [BASE_W-1:0]   chk_base_ff, chk_base_in;
   logic [bffa_pkg::UNIT_W-1:0]   idx_ff, idx_in;
   logic [bffa_pkg::STATUS_W-1:0] res_status_ff, res_status_in;
   logic [bffa_pkg::UNIT_W-1:0]   res_unit_ff, res_unit_in;
   logic                          rsp_vld_ff, rsp_vld_in;
   logic [bffa_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [bffa_pkg::UNIT_W-1:0]   rsp_unit_ff, rsp_unit_in;

   logic [BASE_W-1:0]    limit_ext;
   logic [BASE_W-1:0]    rem;
   logic [BASE_W-1:0]    idx_ext;
   logic [BASE_W-1:0]    seek_end;
   logic                 issue_ok;
   logic [WORD_BITS-1:0] valid_mask;
   logic [WORD_BITS-1:0] masked_free;
   logic [WORD_BITS-1:0] low_free;
   logic [BIT_W-1:0]     bit_sel;
   logic [BIT_W-1:0]     bit_off;
   logic                 found;
   logic                 full;
   logic                 range_err;
   logic                 word_hit;
   logic                 mem_we;
   logic                 mem_re;
   logic [WADDR_W-1:0]   mem_waddr;
   logic [WORD_BITS-1:0] mem_wdata;

   assign limit_ext = BASE_W'(limit);
   assign idx_ext   = BASE_W'(idx_ff);
   assign issue_ok  = base_ff < limit_ext;
   assign rem       = limit_ext - chk_base_ff;
   assign seek_end  = base_ff + BASE_W'(WORD_BITS);
   assign range_err = idx_ext >= limit_ext;
   assign word_hit  = idx_ext < seek_end;
   assign bit_off   = BIT_W'(idx_ext - base_ff);

   // bits past the unit count count as used
   always_comb begin
      valid_mask = '0;
      for (int j = 0; j < WORD_BITS; j++) begin
         valid_mask[j] = BASE_W'(j) < rem;
      end
   end

   assign masked_free = ~rd_data_ff & valid_mask;
   assign low_free    = masked_free & (~masked_free + WORD_BITS'(1));

   // encode the isolated lowest free bit
   always_comb begin
      bit_sel = '0;
      for (int j = 0; j < WORD_BITS; j++) begin
         if (low_free[j]) bit_sel = bit_sel | BIT_W'(j);
      end
   end

   assign found = cmd.alloc_scan && chk_vld_ff && (masked_free != '0);
   assign full  = cmd.alloc_scan && !chk_vld_ff && !issue_ok;

   assign sts.clr_last  = addr_ff == WADDR_W'(NUM_WORDS - 1);
   assign sts.found     = found;
   assign sts.full      = full;
   assign sts.range_err = range_err;
   assign sts.word_hit  = word_hit;
   assign sts.out_free  = !rsp_vld_ff || rsp_tready;

   // memory port control
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = addr_ff;
      mem_wdata = '0;
      if (cmd.clr_step) begin
         mem_we = 1'b1;
      end else if (found) begin
         mem_we    = 1'b1;
         mem_waddr = chk_addr_ff;
         mem_wdata = rd_data_ff | low_free;
      end else if (cmd.free_write) begin
         mem_we    = 1'b1;
         mem_wdata = rd_data_ff & ~(WORD_BITS'(1) << bit_off);
      end
   end

   assign mem_re = (cmd.alloc_scan && issue_ok && !found) ||
                   (cmd.free_seek && word_hit && !range_err);

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= mem[addr_ff];
      end
   end

   // pointer, result and reply updates
   always_comb begin
      addr_in       = addr_ff;
      base_in       = base_ff;
      chk_vld_in    = chk_vld_ff;
      chk_addr_in   = chk_addr_ff;
      chk_base_in   = chk_base_ff;
      idx_in        = idx_ff;
      res_status_in = res_status_ff;
      res_unit_in   = res_unit_ff;
      rsp_vld_in    = rsp_vld_ff;
      rsp_status_in = rsp_status_ff;
      rsp_unit_in   = rsp_unit_ff;

      if (cmd.clr_step) begin
         addr_in = addr_ff + WADDR_W'(1);
      end

      if (cmd.load_req) begin
         addr_in    = '0;
         base_in    = '0;
         chk_vld_in = 1'b0;
         idx_in     = req_unit;
      end

      if (cmd.alloc_scan) begin
         chk_vld_in  = issue_ok && !found;
         chk_addr_in = addr_ff;
         chk_base_in = base_ff;
         if (issue_ok && !found) begin
            addr_in = addr_ff + WADDR_W'(1);
            base_in = seek_end;
         end
         if (found) begin
            res_status_in = bffa_pkg::STATUS_OK;
            res_unit_in   = bffa_pkg::UNIT_W'(chk_base_ff + BASE_W'(bit_sel));
         end else if (full) begin
            res_status_in = bffa_pkg::STATUS_FULL;
            res_unit_in   = '0;
         end
      end

      if (cmd.free_seek) begin
         if (range_err) begin
            res_status_in = bffa_pkg::STATUS_RANGE;
            res_unit_in   = '0;
         end else if (!word_hit) begin
            addr_in = addr_ff + WADDR_W'(1);
            base_in = seek_end;
         end
      end

      if (cmd.free_write) begin
         res_status_in = bffa_pkg::STATUS_OK;
         res_unit_in   = '0;
      end

      if (cmd.load_rsp) begin
         rsp_vld_in    = 1'b1;
         rsp_status_in = res_status_ff;
         rsp_unit_in   = res_unit_ff;
      end else if (rsp_tready) begin
         rsp_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         addr_ff    <= '0;
         chk_vld_ff <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         addr_ff    <= addr_in;
         chk_vld_ff <= chk_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      base_ff       <= base_in;
      chk_addr_ff   <= chk_addr_in;
      chk_base_ff   <= chk_base_in;
      idx_ff        <= idx_in;
      res_status_ff <= res_status_in;
      res_unit_ff   <= res_unit_in;
      rsp_status_ff <= rsp_status_in;
      rsp_unit_ff   <= rsp_unit_in;
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_unit   = rsp_unit_ff;

   `BFFA_ASSERT_NEXT(a_load_shows_reply, clock, reset, cmd.load_rsp, rsp_vld_ff,
      "reply load did not raise valid")
   `BFFA_ASSERT_IMPL(a_unit_zero_unless_ok, clock, reset,
      rsp_vld_ff && rsp_status_ff != bffa_pkg::STATUS_OK, rsp_unit_ff == '0,
      "granted unit nonzero on a failed or free reply")

endmodule

// File: hdl/bitmap_first_fit_allocator.sv
// allocate scans the bitmap words in order up to the first word holding a free unit,
//   or through every word within the unit count when the bitmap is full
// free walks the words up to the word of its unit, and an out of range unit answers without a memory access
// one item at a time: the word pointer walks the single-port bitmap memory one word a cycle
// reset: after reset a clearing pass writes every bitmap word to zero,
//   with no item accepted; configuration writes are taken throughout
// ----------------------------------------------------------------------------
// bitmap_first_fit_allocator
// first-fit unit allocator over a usage bitmap with an apb configuration port
// ----------------------------------------------------------------------------
module bitmap_first_fit_allocator #(
   parameter int NUM_UNITS = 4096,
   parameter int WORD_BITS = 32
) (
   input  logic                               clock,
   input  logic                               reset,
   // request channel
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [bffa_pkg::TDATA_W-1:0]       req_tdata,   // [11:0] unit_index
   input  logic                               req_tuser,   // [0] mode
   // reply channel
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [bffa_pkg::TDATA_W-1:0]       rsp_tdata,   // [11:0] granted_unit
   output logic [bffa_pkg::STATUS_W-1:0]      rsp_tuser,   // [1:0] status
   // configuration port
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [bffa_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [bffa_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [bffa_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                               csr_pready
);

   logic [bffa_pkg::CFG_W-1:0]    units_ff, units_in;
   logic [bffa_pkg::CFG_W-1:0]    limit;
   logic                          csr_wr;
   logic                          csr_hit;
   bffa_pkg::bffa_cmd_type        cmd;
   bffa_pkg::bffa_sts_type        sts;
   logic [bffa_pkg::STATUS_W-1:0] rsp_status;
   logic [bffa_pkg::UNIT_W-1:0]   rsp_unit;

   // register file: one register, units_in_use at byte address 0
   assign csr_pready = 1'b1;
   assign csr_hit    = csr_paddr[bffa_pkg::CSR_ADDR_W-1] == bffa_pkg::CSR_IDX_UNITS_IN_USE;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      units_in = units_ff;
      if (csr_wr && csr_hit) units_in = csr_pwdata[bffa_pkg::CFG_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         units_ff <= bffa_pkg::CFG_RESET;
      end else begin
         units_ff <= units_in;
      end
   end

   assign csr_prdata = csr_hit ? bffa_pkg::CSR_DATA_W'(units_ff) : '0;

   // count above the bitmap capacity saturates to it
   always_comb begin
      if (32'(units_ff) > NUM_UNITS) limit = bffa_pkg::CFG_W'(NUM_UNITS);
      else limit = units_ff;
   end

   bffa_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_mode   (req_tuser),
      .sts        (sts),
      .cmd        (cmd)
   );

   bffa_datapath #(
      .NUM_UNITS (NUM_UNITS),
      .WORD_BITS (WORD_BITS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .limit      (limit),
      .req_unit   (req_tdata[bffa_pkg::UNIT_W-1:0]),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_status (rsp_status),
      .rsp_unit   (rsp_unit)
   );

   // reply payload, granted unit zero-extended to whole bytes
   assign rsp_tdata = bffa_pkg::TDATA_W'(rsp_unit);
   assign rsp_tuser = rsp_status;

endmodule

// File: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the bitmap first-fit allocator: a directed opening
// walks the count extremes and corner cases, then randomized phases of
// allocate and free traffic run under varied backpressure. every reply is
// checked against a bit-accurate usage bitmap held in the scoreboard
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int UNIT_COUNT    = 4096;
   localparam int BITS_PER_WORD = 32;

   // register addresses, one 32-bit register per word
   localparam logic [bffa_pkg::CSR_ADDR_W-1:0] CSR_ADDR_UNITS   = 3'd0;
   localparam logic [bffa_pkg::CSR_ADDR_W-1:0] CSR_ADDR_UNKNOWN = 3'd4;

   // quiet cycles before a register write, and the tail at the end of the run
   localparam int IDLE_GAP    = 8;
   localparam int END_TAIL    = 140;
   localparam int DRAIN_LIMIT = 50000;
   localparam int HOLD_OFF    = 400;

   typedef struct packed {
      logic [bffa_pkg::STATUS_W-1:0] status;
      logic [bffa_pkg::UNIT_W-1:0]   granted;
   } alloc_reply_type;

   // ----------------------------------------------------------------------
   // scoreboard: mirrors the usage bitmap and the unit count, predicts one
   // reply per accepted request and checks replies in order
   // ----------------------------------------------------------------------
   class alloc_scoreboard_type;
      bit [UNIT_COUNT-1:0]          usage;
      logic [bffa_pkg::CFG_W-1:0]   units_in_use;
      alloc_reply_type              pending_replies[$];
      int                           fail_count;

      function new();
         usage        = '0;
         units_in_use = bffa_pkg::CFG_RESET;
         fail_count   = 0;
      endfunction

      function int unsigned covered_units();
         return (units_in_use > UNIT_COUNT) ? UNIT_COUNT : units_in_use;
      endfunction

      function int pending();
         return pending_replies.size();
      endfunction

      // first fit over the covered units, or clear one bit, or flag a unit out of range
      function void note_request(logic mode, logic [bffa_pkg::UNIT_W-1:0] idx);
         int unsigned     lim;
         alloc_reply_type rep;
         lim         = covered_units();
         rep.status  = bffa_pkg::STATUS_OK;
         rep.granted = '0;
         if (mode == bffa_pkg::MODE_ALLOC) begin
            rep.status = bffa_pkg::STATUS_FULL;
            for (int u = 0; u < lim; u++) begin
               if (!usage[u]) begin
                  usage[u]    = 1'b1;
                  rep.status  = bffa_pkg::STATUS_OK;
                  rep.granted = u[bffa_pkg::UNIT_W-1:0];
                  break;
               end
            end
         end else if (idx >= lim) begin
            rep.status = bffa_pkg::STATUS_RANGE;
         end else begin
            usage[idx] = 1'b0;
         end
         pending_replies.push_back(rep);
      endfunction

      task report(string msg);
         fail_count++;
         $display("ERROR %0t: %s", $time, msg);
      endtask

      task check_reply(logic [bffa_pkg::STATUS_W-1:0] got_status,
                       logic [bffa_pkg::TDATA_W-1:0] got_data);
         alloc_reply_type exp;
         if (pending_replies.size() == 0) begin
            report($sformatf("unexpected reply status=%0d data=%0d", got_status, got_data));
         end else begin
            exp = pending_replies.pop_front();
            if (got_status !== exp.status)
               report($sformatf("status got %0d expected %0d", got_status, exp.status));
            if (got_data !== {{(bffa_pkg::TDATA_W-bffa_pkg::UNIT_W){1'b0}}, exp.granted})
               report($sformatf("granted unit got %0d expected %0d", got_data, exp.granted));
         end
      endtask
   endclass

   // ----------------------------------------------------------------------
   // clock, reset and dut signals
   // ----------------------------------------------------------------------
   logic clock = 1'b0;
   logic reset;

   logic                            req_tvalid;
   logic                            req_tready;
   logic [bffa_pkg::TDATA_W-1:0]    req_tdata;   // [11:0] unit_index
   logic                            req_tuser;   // [0] mode
   logic                            rsp_tvalid;
   logic                            rsp_tready;
   logic [bffa_pkg::TDATA_W-1:0]    rsp_tdata;   // [11:0] granted_unit
   logic [bffa_pkg::STATUS_W-1:0]   rsp_tuser;   // [1:0] status
   logic                            csr_psel;
   logic                            csr_penable;
   logic                            csr_pwrite;
   logic [bffa_pkg::CSR_ADDR_W-1:0] csr_paddr;
   logic [bffa_pkg::CSR_DATA_W-1:0] csr_pwdata;
   logic [bffa_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                            csr_pready;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   bitmap_first_fit_allocator #(
      .NUM_UNITS (UNIT_COUNT),
      .WORD_BITS (BITS_PER_WORD)
   ) u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   alloc_scoreboard_type sb = new();

   // idling knobs, changed between phases by the stimulus process
   int unsigned send_idle_pct  = 0;
   int unsigned recv_stall_pct = 0;
   // long receiver hold-off, requested by stimulus, counted down by the receiver
   int          hold_off_len   = 0;

   // ----------------------------------------------------------------------
   // reply side: checks accepted items, randomizes tready
   // ----------------------------------------------------------------------
   initial begin : reply_side
      int hold_left;
      hold_left  = 0;
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         // sampled values are the ones from before this edge
         if (!reset && rsp_tvalid && rsp_tready)
            sb.check_reply(rsp_tuser, rsp_tdata);
         if (hold_off_len > 0) begin
            hold_left    = hold_off_len;
            hold_off_len = 0;
         end
         if (hold_left > 0) begin
            // long stall so the block backs up into the request channel
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   // ----------------------------------------------------------------------
   // request side helpers; each is entered right after a rising edge
   // ----------------------------------------------------------------------
   task automatic send_item(input logic mode, input logic [bffa_pkg::UNIT_W-1:0] idx);
      // a random gap only drops valid; back-to-back items keep it high
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= {{(bffa_pkg::TDATA_W-bffa_pkg::UNIT_W){1'b0}}, idx};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_request(mode, idx);
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      // free of an out-of-range unit answers early; leave room for any tail work
      repeat (IDLE_GAP) @(posedge clock);
   endtask

   // setup cycle then access cycle; the register lands on the access edge
   task automatic write_csr(input logic [bffa_pkg::CSR_ADDR_W-1:0] addr,
                            input logic [bffa_pkg::CSR_DATA_W-1:0] value);
      wait_idle();
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      // writes to an unmapped address leave the count alone
      if (addr == CSR_ADDR_UNITS)
         sb.units_in_use = value[bffa_pkg::CFG_W-1:0];
   endtask

   task automatic alloc_unit();
      send_item(bffa_pkg::MODE_ALLOC, bffa_pkg::UNIT_W'($urandom_range(0, 4095)));
   endtask

   task automatic free_unit(input logic [bffa_pkg::UNIT_W-1:0] idx);
      send_item(bffa_pkg::MODE_FREE, idx);
   endtask

   // one randomized phase: count setting, traffic mix and idling profile
   task automatic run_phase(input int unsigned count, input int unsigned n_items,
                            input int unsigned alloc_pct, input int unsigned s_idle,
                            input int unsigned r_stall, input bit with_hold);
      int unsigned lim;
      int unsigned span;
      int unsigned sel;
      int          edge_idx;
      logic [bffa_pkg::UNIT_W-1:0] idx;
      write_csr(CSR_ADDR_UNITS, count);
      send_idle_pct  = s_idle;
      recv_stall_pct = r_stall;
      lim  = sb.covered_units();
      span = (lim < 64) ? lim : 64;
      if (with_hold)
         hold_off_len = HOLD_OFF;
      for (int i = 0; i < n_items; i++) begin
         if ($urandom_range(99) < alloc_pct) begin
            alloc_unit();
         end else begin
            sel = $urandom_range(99);
            if (sel < 55) begin
               // mostly the low region where allocations land
               idx = bffa_pkg::UNIT_W'($urandom_range(0, span));
            end else if (sel < 80) begin
               idx = bffa_pkg::UNIT_W'($urandom_range(0, 4095));
            end else begin
               // just below, at and above the covered count
               edge_idx = int'(lim) + int'($urandom_range(0, 2)) - 1;
               idx      = edge_idx[bffa_pkg::UNIT_W-1:0];
            end
            free_unit(idx);
         end
      end
   endtask

   // ----------------------------------------------------------------------
   // stimulus
   // ----------------------------------------------------------------------
   initial begin : stimulus
      int waited;
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = bffa_pkg::MODE_ALLOC;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed opening; first items wait out the clearing pass after reset
      alloc_unit();                      // unit 0
      alloc_unit();                      // unit 1
      alloc_unit();                      // unit 2
      free_unit(12'd1);
      free_unit(12'd1);                  // freeing a free unit is harmless
      alloc_unit();                      // lowest hole refilled
      free_unit(12'hFFF);                // top index, already free
      free_unit(12'h800);

      // count of zero covers nothing
      write_csr(CSR_ADDR_UNITS, 32'd0);
      alloc_unit();
      free_unit(12'd0);

      // count above capacity saturates to the full bitmap
      write_csr(CSR_ADDR_UNITS, 32'h1FFF);
      free_unit(12'hFFF);
      alloc_unit();

      // count lowered below used units: those bits stay set but unseen
      write_csr(CSR_ADDR_UNITS, 32'd2);
      alloc_unit();
      free_unit(12'd2);
      free_unit(12'd1);
      alloc_unit();

      // single unit, then a write to an unmapped register
      write_csr(CSR_ADDR_UNITS, 32'd1);
      free_unit(12'd0);
      alloc_unit();
      alloc_unit();
      write_csr(CSR_ADDR_UNKNOWN, 32'd0);
      free_unit(12'd1);
      free_unit(12'd0);

      // back to the full count; the hidden units are seen again
      write_csr(CSR_ADDR_UNITS, 32'd4096);
      alloc_unit();
      free_unit(12'h555);
      free_unit(12'hAAA);

      // randomized phases: no idling, sender gaps, receiver stalls,
      // light idling on both sides with one long hold-off, then no idling again
      run_phase(4096, 90, 55,  0,  0, 1'b0);
      run_phase(48,   90, 60, 48,  0, 1'b0);
      run_phase(8191, 90, 50,  0, 48, 1'b0);
      run_phase(33,   90, 65,  7,  7, 1'b1);
      run_phase(5,    90, 55,  0,  0, 1'b0);

      // drain, then let any trailing work settle
      req_tvalid <= 1'b0;
      for (waited = 0; sb.pending() != 0 && waited < DRAIN_LIMIT; waited++)
         @(posedge clock);
      repeat (END_TAIL) @(posedge clock);
      if (sb.pending() != 0)
         sb.report($sformatf("%0d replies never arrived", sb.pending()));

      if (sb.fail_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   // ----------------------------------------------------------------------
   // watchdog: far beyond the slowest legal run
   // ----------------------------------------------------------------------
   initial begin : watchdog
      #10_000_000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule

// File: filelist.f
+incdir+hdl
hdl/bffa_pkg.sv
hdl/bffa_ctrl.sv
hdl/bffa_datapath.sv
hdl/bitmap_first_fit_allocator.sv
sim/tb_top.sv
